// ===== sv/ow_pkg.sv =====
// ----------------------------------------------------------------------------
// ow_pkg: shared types and constants of the 1-Wire bus master
// Beat payloads, command codes, sequencer phases and bus timing in microseconds.
// ----------------------------------------------------------------------------
package ow_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_CYCLES_PER_US = 2'd0;
  localparam logic [7:0]            CYCLES_PER_US_RST  = 8'd168;

  localparam logic [9:0] T_RST_LOW  = 10'd500;
  localparam logic [9:0] T_RST_SAMP = 10'd100;
  localparam logic [9:0] T_RST_HOLD = 10'd200;
  localparam logic [9:0] T_WR_LOW1  = 10'd5;
  localparam logic [9:0] T_WR_LOW0  = 10'd60;
  localparam logic [9:0] T_RD_LOW   = 10'd2;
  localparam logic [9:0] T_RD_SAMP  = 10'd14;
  localparam logic [9:0] T_SLOT     = 10'd62;
  localparam logic [7:0] CRC_POLY   = 8'h31;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_HOLD = 3'd3,
    PH_WRITE    = 3'd4,
    PH_READ     = 3'd5
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] tx_byte;
    logic       line_in;
  } in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       device_present;
    logic [7:0] rx_byte;
    logic [7:0] crc_value;
  } out_t;

endpackage

// ===== sv/ow_core.sv =====
// ----------------------------------------------------------------------------
// ow_core: 1-Wire command sequencer
// Holds the prescaler, microsecond counter, phase, shift register and CRC, and
// computes the next state and the result of every accepted beat.
// ----------------------------------------------------------------------------
module ow_core import ow_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] cycles_per_us,
  input  logic       step,
  input  in_t        item,
  output out_t       result
);

  phase_t     phase, phase_next;
  logic [7:0] prescale_count, prescale_count_next;
  logic [9:0] us_count, us_count_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_data, shift_data_next;
  logic [7:0] crc_reg, crc_reg_next;
  logic       present_flag, present_flag_next;
  logic [7:0] rx_last, rx_last_next;
  logic       tick;
  logic       done;
  logic       drive;

  function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic b);
    logic [7:0] c;
    c = {crc[6:0], 1'b0};
    if (crc[7] ^ b) begin
      c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  always_comb begin
    phase_next          = phase;
    prescale_count_next = prescale_count;
    us_count_next       = us_count;
    bit_index_next      = bit_index;
    shift_data_next     = shift_data;
    crc_reg_next        = crc_reg;
    present_flag_next   = present_flag;
    rx_last_next        = rx_last;
    tick                = 1'b0;
    done                = 1'b0;
    drive               = 1'b0;

    if (phase == PH_IDLE) begin
      if (item.op != OP_NONE) begin
        prescale_count_next = '0;
        us_count_next       = '0;
        bit_index_next      = '0;
      end
      case (item.op)
        OP_RESET: begin
          phase_next        = PH_RST_LOW;
          present_flag_next = 1'b0;
          crc_reg_next      = '0;
        end
        OP_WRITE: begin
          phase_next      = PH_WRITE;
          shift_data_next = item.tx_byte;
        end
        OP_READ: begin
          phase_next      = PH_READ;
          shift_data_next = '0;
        end
        default: begin
        end
      endcase
    end else begin
      if ({1'b0, prescale_count} + 9'd1 >= {1'b0, cycles_per_us}) begin
        prescale_count_next = '0;
        tick                = 1'b1;
        us_count_next       = us_count + 10'd1;
      end else begin
        prescale_count_next = prescale_count + 8'd1;
      end
      if (tick) begin
        case (phase)
          PH_RST_LOW: begin
            if (us_count_next >= T_RST_LOW) begin
              phase_next    = PH_RST_WAIT;
              us_count_next = '0;
            end
          end
          PH_RST_WAIT: begin
            if (us_count_next >= T_RST_SAMP) begin
              us_count_next = '0;
              if (!item.line_in) begin
                present_flag_next = 1'b1;
                phase_next        = PH_RST_HOLD;
              end else begin
                phase_next = PH_IDLE;
                done       = 1'b1;
              end
            end
          end
          PH_RST_HOLD: begin
            if (us_count_next >= T_RST_HOLD) begin
              us_count_next = '0;
              phase_next    = PH_IDLE;
              done          = 1'b1;
            end
          end
          PH_WRITE, PH_READ: begin
            if (phase == PH_READ && us_count_next == T_RD_SAMP) begin
              shift_data_next = {item.line_in, shift_data[7:1]};
              crc_reg_next    = crc_bit(crc_reg, item.line_in);
            end
            if (us_count_next >= T_SLOT) begin
              us_count_next = '0;
              if (phase == PH_WRITE) begin
                shift_data_next = {1'b0, shift_data_next[7:1]};
              end
              if (bit_index == 3'd7) begin
                if (phase == PH_READ) begin
                  rx_last_next = shift_data_next;
                end
                bit_index_next = '0;
                phase_next     = PH_IDLE;
                done           = 1'b1;
              end else begin
                bit_index_next = bit_index + 3'd1;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end

    case (phase_next)
      PH_RST_LOW: begin
        drive = 1'b1;
      end
      PH_WRITE: begin
        drive = (us_count_next < T_WR_LOW1) ||
                (!shift_data_next[0] && us_count_next < T_WR_LOW0);
      end
      PH_READ: begin
        drive = us_count_next < T_RD_LOW;
      end
      default: begin
        drive = 1'b0;
      end
    endcase

    result.drive_low      = drive;
    result.busy_res       = phase_next != PH_IDLE;
    result.done_res       = done;
    result.device_present = present_flag_next;
    result.rx_byte        = rx_last_next;
    result.crc_value      = rev8(crc_reg_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      prescale_count <= '0;
      us_count       <= '0;
      bit_index      <= '0;
      shift_data     <= '0;
      crc_reg        <= '0;
      present_flag   <= 1'b0;
      rx_last        <= '0;
    end else if (step) begin
      phase          <= phase_next;
      prescale_count <= prescale_count_next;
      us_count       <= us_count_next;
      bit_index      <= bit_index_next;
      shift_data     <= shift_data_next;
      crc_reg        <= crc_reg_next;
      present_flag   <= present_flag_next;
      rx_last        <= rx_last_next;
    end
  end

endmodule

// ===== sv/ow_outq.sv =====
// ----------------------------------------------------------------------------
// ow_outq: result register with skid stage
// Registers each result beat and keeps one extra beat while the receiver
// stalls, so the input side never waits on the output ready combinationally.
// ----------------------------------------------------------------------------
module ow_outq import ow_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  out_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic main_valid;
  logic skid_valid;
  out_t main_data;
  out_t skid_data;
  logic pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data <= push_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/onewire_bus_master.sv =====
// ----------------------------------------------------------------------------
// onewire_bus_master: 1-Wire bus master with Maxim CRC-8 over read bytes
// Bus timing counts accepted input beats, not clock edges. The input beat
// carries the command, the byte to send and the sampled bus level; the output
// beat carries the pull-down request, busy, done, presence, the last byte
// read and the bit-reversed CRC. A command is taken only while idle.
// A result is formed combinationally and registered at the output.
// Throughput is one beat per cycle while in_ready is high, set by the single
// register stage of the sequencer state. A two-entry result queue sits at
// the output; in_ready falls only when both entries are full and the
// receiver holds out_ready low, and rises as soon as one beat is taken.
// Reset clears the sequencer to idle, sets the prescaler setting to
// CYCLES_PER_US_RST and empties the queue. cycles_per_us is written through
// the APB port at address 0 and should change only while the bus is idle.
// ----------------------------------------------------------------------------
module onewire_bus_master import ow_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [7:0] cycles_per_us;
  logic       step;
  out_t       result;

  assign pready = 1'b1;
  assign step   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_us <= CYCLES_PER_US_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_CYCLES_PER_US) begin
      cycles_per_us <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CYCLES_PER_US) begin
      prdata = {{(CFG_DATA_W-8){1'b0}}, cycles_per_us};
    end
  end

  ow_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cycles_per_us (cycles_per_us),
    .step          (step),
    .item          (in_data),
    .result        (result)
  );

  ow_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/ow_checker.sv =====
// ----------------------------------------------------------------------------
// ow_checker: port-level checks of the 1-Wire bus master
// Watches the result channel for reset behavior, stall behavior and
// consistency of the status flags.
// ----------------------------------------------------------------------------
module ow_checker import ow_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Result queue not empty after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed or vanished.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("Done reported while still busy.");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_low |-> out_data.busy_res)
    else $error("Bus pulled low while idle.");

  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_ready |=> in_ready)
    else $error("Input stayed blocked after a result beat was taken.");

endmodule

bind onewire_bus_master ow_checker u_ow_checker (.*);

// ===== dv/tb_onewire_bus_master.sv =====
// ----------------------------------------------------------------------------
// tb_onewire_bus_master: self-checking bench for the 1-Wire bus master
// Bus timing counts accepted input beats. An internal shadow of the
// sequencer predicts the status beat that each accepted input beat produces,
// and the output monitor compares every status beat field by field. The
// stimulus reads a byte at one prescaler setting and then runs a reset with
// no device at the zero prescaler setting, with stray commands while busy.
// Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_onewire_bus_master;
  import ow_pkg::*;

  class onewire_shadow;
    logic [7:0] cpu = CYCLES_PER_US_RST;
    phase_t     phase = PH_IDLE;
    logic [7:0] presc = '0;
    logic [9:0] usec = '0;
    logic [2:0] bit_idx = '0;
    logic [7:0] shreg = '0;
    logic [7:0] crc = '0;
    logic       present = 1'b0;
    logic [7:0] rx_last = '0;
    out_t       status_q[$];
    int         mismatches = 0;

    function logic [7:0] crc_shown();
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = crc[7-i];
      return r;
    endfunction

    function void accept_in_beat(in_t b);
      out_t e;
      logic tick;
      logic done;
      logic fb;
      done = 1'b0;
      if (phase == PH_IDLE) begin
        if (b.op != OP_NONE) begin
          presc = '0;
          usec = '0;
          bit_idx = '0;
          case (b.op)
            OP_RESET: begin
              phase = PH_RST_LOW;
              present = 1'b0;
              crc = '0;
            end
            OP_WRITE: begin
              phase = PH_WRITE;
              shreg = b.tx_byte;
            end
            default: begin
              phase = PH_READ;
              shreg = '0;
            end
          endcase
        end
      end else begin
        tick = ({1'b0, presc} + 9'd1 >= {1'b0, cpu});
        if (tick) begin
          presc = '0;
          usec = usec + 10'd1;
        end else begin
          presc = presc + 8'd1;
        end
        if (tick) begin
          case (phase)
            PH_RST_LOW: begin
              if (usec >= T_RST_LOW) begin
                phase = PH_RST_WAIT;
                usec = '0;
              end
            end
            PH_RST_WAIT: begin
              if (usec >= T_RST_SAMP) begin
                usec = '0;
                if (!b.line_in) begin
                  present = 1'b1;
                  phase = PH_RST_HOLD;
                end else begin
                  phase = PH_IDLE;
                  done = 1'b1;
                end
              end
            end
            PH_RST_HOLD: begin
              if (usec >= T_RST_HOLD) begin
                usec = '0;
                phase = PH_IDLE;
                done = 1'b1;
              end
            end
            PH_WRITE, PH_READ: begin
              if (phase == PH_READ && usec == T_RD_SAMP) begin
                shreg = {b.line_in, shreg[7:1]};
                fb = crc[7] ^ b.line_in;
                crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
              end
              if (usec >= T_SLOT) begin
                usec = '0;
                if (phase == PH_WRITE) shreg = shreg >> 1;
                if (bit_idx == 3'd7) begin
                  if (phase == PH_READ) rx_last = shreg;
                  bit_idx = '0;
                  phase = PH_IDLE;
                  done = 1'b1;
                end else begin
                  bit_idx = bit_idx + 3'd1;
                end
              end
            end
            default: phase = PH_IDLE;
          endcase
        end
      end

      case (phase)
        PH_RST_LOW: e.drive_low = 1'b1;
        PH_WRITE:   e.drive_low = (usec < T_WR_LOW1) || (!shreg[0] && usec < T_WR_LOW0);
        PH_READ:    e.drive_low = (usec < T_RD_LOW);
        default:    e.drive_low = 1'b0;
      endcase
      e.busy_res = (phase != PH_IDLE);
      e.done_res = done;
      e.device_present = present;
      e.rx_byte = rx_last;
      e.crc_value = crc_shown();
      status_q.push_back(e);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_out_beat(out_t got);
      out_t want;
      if (status_q.size() == 0) begin
        $display("%0t: status beat with nothing expected, actual %0h", $time, got);
        mismatches++;
        return;
      end
      want = status_q.pop_front();
      check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
      check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      check_field("done_res", 8'(want.done_res), 8'(got.done_res));
      check_field("device_present", 8'(want.device_present), 8'(got.device_present));
      check_field("rx_byte", want.rx_byte, got.rx_byte);
      check_field("crc_value", want.crc_value, got.crc_value);
    endfunction
  endclass

  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  onewire_shadow shadow;
  bit idling_on;
  bit noisy_line;
  bit hold_req;
  logic dev_present;
  logic [7:0] dev_byte;

  onewire_bus_master DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 72) return 0;
    if (r < 98) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The device side answers on the sampled level that the sequencer is waiting for.
  function automatic logic line_level();
    if (noisy_line && $urandom_range(0, 3) == 0) return 1'($urandom_range(0, 1));
    case (shadow.phase)
      PH_RST_WAIT: return !dev_present;
      PH_READ:     return dev_byte[shadow.bit_idx];
      default:     return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_beat(in_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    shadow.accept_in_beat(b);
  endtask

  task automatic run_cmd(op_t op, logic [7:0] tx);
    in_t b;
    logic [1:0] rop;
    int idle_n;
    b.op = op;
    b.tx_byte = tx;
    b.line_in = line_level();
    send_beat(b);
    while (shadow.phase != PH_IDLE) begin
      rop = 2'($urandom_range(0, 3));
      b.op = ($urandom_range(0, 49) == 0) ? op_t'(rop) : OP_NONE;
      b.tx_byte = 8'($urandom_range(0, 255));
      b.line_in = line_level();
      send_beat(b);
    end
    idle_n = $urandom_range(0, 3);
    repeat (idle_n) begin
      b.op = OP_NONE;
      b.tx_byte = 8'($urandom_range(0, 255));
      b.line_in = 1'($urandom_range(0, 1));
      send_beat(b);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (shadow.status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_prescale(logic [7:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_CYCLES_PER_US;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== want) begin
      $display("%0t: cycles_per_us readback, expected %0h, actual %0h", $time, want,
               prdata[7:0]);
      shadow.mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_prescale(logic [7:0] v);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_CYCLES_PER_US;
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow.cpu = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_prescale(v);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) shadow.check_out_beat(out_data);
  end

  initial begin
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold == 0) hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #300000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    shadow = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idling_on = 1'b1;
    noisy_line = 1'b0;
    hold_req = 1'b0;
    dev_present = 1'b1;
    dev_byte = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    read_prescale(CYCLES_PER_US_RST);
    set_prescale(8'd1);
    dev_byte = 8'h5A;
    hold_req = 1'b1;
    run_cmd(OP_READ, 8'h00);

    set_prescale(8'd0);
    dev_present = 1'b0;
    run_cmd(OP_RESET, 8'(($urandom_range(0, 255))));

    wait_drained();
    repeat (8) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ow_pkg.sv
sv/ow_core.sv
sv/ow_outq.sv
sv/onewire_bus_master.sv
sv/ow_checker.sv
dv/tb_onewire_bus_master.sv
